### rtl/differential_drive_odometry_assert.svh
// ----------------------------------------------------------------------------
// differential drive odometry assertion macros
// shared property forms, clocked on clk and quiet while rst_n is low
// ----------------------------------------------------------------------------
`ifndef DIFFERENTIAL_DRIVE_ODOMETRY_ASSERT_SVH
`define DIFFERENTIAL_DRIVE_ODOMETRY_ASSERT_SVH

// consequent holds in the same cycle
`define DDO_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("odometry assertion failed");

// consequent holds in the next cycle
`define DDO_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("odometry assertion failed");

`endif

### rtl/ddo_pkg.sv
// ----------------------------------------------------------------------------
// ddo_pkg
// widths, constants and helper functions for the odometry block
// ----------------------------------------------------------------------------
package ddo_pkg;

    localparam int TIME_W = 44;
    localparam int SPD_W  = 24;
    localparam int POS_W  = 32;
    localparam int TW_W   = 24;
    localparam int THR_W  = 16;
    localparam int CFG_D_W = 24;

    localparam int CORDIC_STEPS = 24;
    localparam int CS_W = 34;
    localparam int Z_W  = 33;

    localparam int MUL_A_W = 64;
    localparam int MUL_B_W = 45;
    localparam int MUL_P_W = 72;

    localparam int DIV_N_W = 64;
    localparam int DIV_D_W = 32;

    localparam int SH_W = MUL_P_W - 30;
    localparam int DF_W = MUL_P_W - 20;
    localparam int DYAW_LSB = 28;

    localparam logic [TW_W-1:0]  TW_RESET  = 24'd98304;
    localparam logic [THR_W-1:0] THR_RESET = 16'd7;

    localparam logic REG_TRACK_WIDTH = 1'b0;
    localparam logic REG_MOTION_THR  = 1'b1;

    localparam logic signed [CS_W-1:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic [MUL_A_W-1:0] ANG_PER_RAD_Q8 = 64'd174992710548;
    localparam logic signed [CS_W-1:0] D_LIM = 34'sh1_0000_0000;
    localparam logic [DIV_N_W-1:0] R_LIM = 64'd2147483647;
    localparam logic signed [POS_W-1:0] POS_MAX = 32'sh7fff_ffff;
    localparam logic signed [POS_W-1:0] POS_MIN = 32'sh8000_0000;

    function automatic logic [31:0] atan_ba(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:  v = 32'd536870912;
            5'd1:  v = 32'd316933406;
            5'd2:  v = 32'd167458907;
            5'd3:  v = 32'd85007316;
            5'd4:  v = 32'd42667331;
            5'd5:  v = 32'd21354465;
            5'd6:  v = 32'd10679838;
            5'd7:  v = 32'd5340245;
            5'd8:  v = 32'd2670163;
            5'd9:  v = 32'd1335087;
            5'd10: v = 32'd667544;
            5'd11: v = 32'd333772;
            5'd12: v = 32'd166886;
            5'd13: v = 32'd83443;
            5'd14: v = 32'd41722;
            5'd15: v = 32'd20861;
            5'd16: v = 32'd10430;
            5'd17: v = 32'd5215;
            5'd18: v = 32'd2608;
            5'd19: v = 32'd1304;
            5'd20: v = 32'd652;
            5'd21: v = 32'd326;
            5'd22: v = 32'd163;
            5'd23: v = 32'd81;
            5'd24: v = 32'd41;
            5'd25: v = 32'd20;
            5'd26: v = 32'd10;
            5'd27: v = 32'd5;
            5'd28: v = 32'd3;
            5'd29: v = 32'd1;
            5'd30: v = 32'd1;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

    // position plus shifted increment, clipped to the signed position range
    function automatic logic signed [POS_W-1:0] sat_add(
        input logic signed [POS_W-1:0] acc,
        input logic signed [SH_W-1:0]  inc
    );
        logic signed [SH_W+1:0] s;
        s = (SH_W+2)'(acc) + (SH_W+2)'(inc);
        if (s > (SH_W+2)'(POS_MAX))
            return POS_MAX;
        else if (s < (SH_W+2)'(POS_MIN))
            return POS_MIN;
        else
            return s[POS_W-1:0];
    endfunction

endpackage

### rtl/ddo_if.sv
// ----------------------------------------------------------------------------
// ddo channel interfaces
// wheel sample input, pose result output and register write channels
// ----------------------------------------------------------------------------
interface ddo_in_if import ddo_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic                    opcode;
    logic [TIME_W-1:0]       sample_time;
    logic signed [SPD_W-1:0] right_speed;
    logic signed [SPD_W-1:0] left_speed;

    modport source (output valid, opcode, sample_time, right_speed, left_speed,
                    input ready);
    modport sink (input valid, opcode, sample_time, right_speed, left_speed,
                  output ready);
endinterface

interface ddo_out_if import ddo_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [POS_W-1:0] pose_x;
    logic signed [POS_W-1:0] pose_y;
    logic [POS_W-1:0]        pose_yaw;
    logic signed [SPD_W-1:0] mean_speed;
    logic                    time_latched_only;

    modport source (output valid, pose_x, pose_y, pose_yaw, mean_speed,
                    time_latched_only, input ready);
    modport sink (input valid, pose_x, pose_y, pose_yaw, mean_speed,
                  time_latched_only, output ready);
endinterface

interface ddo_cfg_if import ddo_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               index;
    logic [CFG_D_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

### rtl/ddo_mul.sv
// ----------------------------------------------------------------------------
// ddo_mul
// signed shift-add multiplier, one multiplier bit per cycle
// ----------------------------------------------------------------------------
module ddo_mul import ddo_pkg::*; (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic signed [MUL_A_W-1:0] a,
    input  logic signed [MUL_B_W-1:0] b,
    output logic                      done,
    output logic signed [MUL_P_W-1:0] prod
);

    localparam int CNT_W = $clog2(MUL_B_W);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(MUL_B_W - 1);

    logic signed [MUL_P_W-1:0] mcand_reg;
    logic signed [MUL_P_W-1:0] acc_reg;
    logic signed [MUL_P_W-1:0] acc_next;
    logic [MUL_B_W-1:0]        mplier_reg;
    logic [CNT_W-1:0]          cnt_reg;
    logic                      busy_reg;
    logic                      done_reg;

    // top multiplier bit carries negative weight
    always_comb
    begin
        acc_next = acc_reg;
        if (mplier_reg[0])
        begin
            if (cnt_reg == LAST)
                acc_next = acc_reg - mcand_reg;
            else
                acc_next = acc_reg + mcand_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == LAST);
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == LAST)
                    busy_reg <= 1'b0;
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mcand_reg  <= MUL_P_W'(a);
            mplier_reg <= b;
            acc_reg    <= '0;
        end
        else if (busy_reg)
        begin
            acc_reg    <= acc_next;
            mcand_reg  <= mcand_reg <<< 1;
            mplier_reg <= mplier_reg >> 1;
        end
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

### rtl/ddo_div.sv
// ----------------------------------------------------------------------------
// ddo_div
// unsigned restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module ddo_div import ddo_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [DIV_N_W-1:0] dividend,
    input  logic [DIV_D_W-1:0] divisor,
    output logic               done,
    output logic [DIV_N_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DIV_N_W);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(DIV_N_W - 1);

    logic [DIV_D_W-1:0] rem_reg;
    logic [DIV_N_W-1:0] quo_reg;
    logic [DIV_D_W-1:0] dsor_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               busy_reg;
    logic               done_reg;
    logic [DIV_D_W:0]   trial;
    logic [DIV_D_W:0]   sub;
    logic               fits;

    always_comb
    begin
        trial = {rem_reg, quo_reg[DIV_N_W-1]};
        fits  = trial >= {1'b0, dsor_reg};
        sub   = trial - {1'b0, dsor_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == LAST);
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == LAST)
                    busy_reg <= 1'b0;
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= '0;
            quo_reg  <= dividend;
            dsor_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? sub[DIV_D_W-1:0] : trial[DIV_D_W-1:0];
            quo_reg <= {quo_reg[DIV_N_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

### rtl/ddo_cordic.sv
// ----------------------------------------------------------------------------
// ddo_cordic
// iterative rotation cordic giving cosine and sine of a binary angle
// ----------------------------------------------------------------------------
module ddo_cordic import ddo_pkg::*; (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [POS_W-1:0]       angle,
    output logic                   done,
    output logic signed [CS_W-1:0] cos_val,
    output logic signed [CS_W-1:0] sin_val
);

    localparam int CNT_W = $clog2(CORDIC_STEPS);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(CORDIC_STEPS - 1);

    logic signed [CS_W-1:0] x_reg;
    logic signed [CS_W-1:0] y_reg;
    logic signed [Z_W-1:0]  z_reg;
    logic [1:0]             quad_reg;
    logic [CNT_W-1:0]       cnt_reg;
    logic                   busy_reg;
    logic                   done_reg;
    logic signed [CS_W-1:0] xs;
    logic signed [CS_W-1:0] ys;
    logic signed [Z_W-1:0]  at;

    always_comb
    begin
        xs = x_reg >>> cnt_reg;
        ys = y_reg >>> cnt_reg;
        at = $signed({1'b0, atan_ba(5'(cnt_reg))});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == LAST);
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == LAST)
                    busy_reg <= 1'b0;
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg    <= CORDIC_GAIN;
            y_reg    <= '0;
            z_reg    <= $signed({3'b000, angle[29:0]});
            quad_reg <= angle[31:30];
        end
        else if (busy_reg)
        begin
            if (!z_reg[Z_W-1])
            begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - at;
            end
            else
            begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + at;
            end
        end
    end

    // quadrant fold
    always_comb
    begin
        case (quad_reg)
            2'd0:
            begin
                cos_val = x_reg;
                sin_val = y_reg;
            end
            2'd1:
            begin
                cos_val = -y_reg;
                sin_val = x_reg;
            end
            2'd2:
            begin
                cos_val = -x_reg;
                sin_val = -y_reg;
            end
            default:
            begin
                cos_val = y_reg;
                sin_val = -x_reg;
            end
        endcase
    end

    assign done = done_reg;

endmodule

### rtl/differential_drive_odometry.sv
// ----------------------------------------------------------------------------
// differential_drive_odometry
// planar dead reckoning from wheel speeds, pose kept as x, y and yaw
//
// channel   dir   transfer
// samples   in    opcode, sample_time, right_speed, left_speed
// poses     out   pose_x, pose_y, pose_yaw, mean_speed, time_latched_only
// cfg       in    index, data (register write, always ready)
//
// clear, first sample and standstill go straight to the result, with no arithmetic unit
// straight motion: three multiplies and one cordic
// turn: five multiplies, two divides, two cordics
// the multiplier, divider and cordic are single units shared by all steps
// one sample at a time; a finished pose waits in the output register
// ----------------------------------------------------------------------------
`include "differential_drive_odometry_assert.svh"

module differential_drive_odometry import ddo_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    ddo_in_if.sink   samples,
    ddo_out_if.source poses,
    ddo_cfg_if.sink  cfg
);

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_EVAL   = 5'd1;
    localparam logic [4:0] S_ST_M1  = 5'd2;
    localparam logic [4:0] S_ST_M1W = 5'd3;
    localparam logic [4:0] S_ST_C   = 5'd4;
    localparam logic [4:0] S_ST_CW  = 5'd5;
    localparam logic [4:0] S_ST_M2  = 5'd6;
    localparam logic [4:0] S_ST_M2W = 5'd7;
    localparam logic [4:0] S_ST_M3  = 5'd8;
    localparam logic [4:0] S_ST_M3W = 5'd9;
    localparam logic [4:0] S_TU_M1  = 5'd10;
    localparam logic [4:0] S_TU_M1W = 5'd11;
    localparam logic [4:0] S_TU_D1  = 5'd12;
    localparam logic [4:0] S_TU_D1W = 5'd13;
    localparam logic [4:0] S_TU_M2  = 5'd14;
    localparam logic [4:0] S_TU_M2W = 5'd15;
    localparam logic [4:0] S_TU_D2  = 5'd16;
    localparam logic [4:0] S_TU_D2W = 5'd17;
    localparam logic [4:0] S_TU_M3  = 5'd18;
    localparam logic [4:0] S_TU_M3W = 5'd19;
    localparam logic [4:0] S_TU_C0  = 5'd20;
    localparam logic [4:0] S_TU_C0W = 5'd21;
    localparam logic [4:0] S_TU_C1  = 5'd22;
    localparam logic [4:0] S_TU_C1W = 5'd23;
    localparam logic [4:0] S_TU_M4  = 5'd24;
    localparam logic [4:0] S_TU_M4W = 5'd25;
    localparam logic [4:0] S_TU_M5  = 5'd26;
    localparam logic [4:0] S_TU_M5W = 5'd27;
    localparam logic [4:0] S_FINISH = 5'd28;

    logic [4:0] state_reg;
    logic [4:0] state_next;

    logic [TW_W-1:0]         tw_reg;
    logic [THR_W-1:0]        thr_reg;
    logic                    seen_first_reg;
    logic [TIME_W-1:0]       last_time_reg;
    logic signed [POS_W-1:0] pose_x_reg;
    logic signed [POS_W-1:0] pose_y_reg;
    logic [POS_W-1:0]        yaw_reg;
    logic signed [SPD_W-1:0] mean_reg;
    logic                    latched_reg;

    logic signed [SPD_W-1:0]  r_reg;
    logic signed [SPD_W-1:0]  l_reg;
    logic signed [TIME_W-1:0] dt_reg;
    logic signed [CS_W-1:0]   dist_reg;
    logic signed [POS_W-1:0]  rad_reg;
    logic signed [MUL_A_W-1:0] om_reg;
    logic [DIV_N_W-1:0]       p_reg;
    logic [POS_W-1:0]         ny_reg;
    logic signed [CS_W-1:0]   c0_reg;
    logic signed [CS_W-1:0]   s0_reg;
    logic signed [CS_W-1:0]   c1_reg;
    logic signed [CS_W-1:0]   s1_reg;

    logic                    out_valid_reg;
    logic signed [POS_W-1:0] out_x_reg;
    logic signed [POS_W-1:0] out_y_reg;
    logic [POS_W-1:0]        out_yaw_reg;
    logic signed [SPD_W-1:0] out_mean_reg;
    logic                    out_latched_reg;

    logic                      mul_start;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic                      mul_done;
    logic signed [MUL_P_W-1:0] mul_prod;
    logic                      div_start;
    logic [DIV_N_W-1:0]        div_n;
    logic [DIV_D_W-1:0]        div_d;
    logic                      div_done;
    logic [DIV_N_W-1:0]        div_quo;
    logic                      cor_start;
    logic [POS_W-1:0]          cor_angle;
    logic                      cor_done;
    logic signed [CS_W-1:0]    cor_cos;
    logic signed [CS_W-1:0]    cor_sin;

    logic signed [SPD_W:0] sum_w;
    logic signed [SPD_W:0] diff_w;
    logic [SPD_W:0]        mag_r;
    logic [SPD_W:0]        mag_l;
    logic [SPD_W:0]        mag_sum;
    logic [SPD_W:0]        mag_diff;
    logic [SPD_W:0]        thr_ext;
    logic                  moving;
    logic                  straight;
    logic [TW_W-1:0]       w_eff;
    logic signed [DF_W-1:0] d_full;
    logic signed [CS_W:0]  sin_diff;
    logic signed [CS_W:0]  cos_diff;
    logic [POS_W-1:0]      rad_mag;
    logic                  in_xfer;
    logic                  finish_go;

    assign in_xfer   = samples.valid && samples.ready;
    assign finish_go = (state_reg == S_FINISH) && (!out_valid_reg || poses.ready);

    always_comb
    begin
        sum_w    = {r_reg[SPD_W-1], r_reg} + {l_reg[SPD_W-1], l_reg};
        diff_w   = {r_reg[SPD_W-1], r_reg} - {l_reg[SPD_W-1], l_reg};
        mag_r    = r_reg[SPD_W-1] ? -{r_reg[SPD_W-1], r_reg} : {1'b0, r_reg};
        mag_l    = l_reg[SPD_W-1] ? -{l_reg[SPD_W-1], l_reg} : {1'b0, l_reg};
        mag_sum  = sum_w[SPD_W] ? -sum_w : sum_w;
        mag_diff = diff_w[SPD_W] ? -diff_w : diff_w;
        thr_ext  = (SPD_W+1)'(thr_reg);
        moving   = (mag_r > thr_ext) || (mag_l > thr_ext);
        straight = (mag_diff < thr_ext) || (diff_w == '0);
        // zero track width behaves as one lsb
        w_eff    = (tw_reg == '0) ? TW_W'(1) : tw_reg;
        d_full   = mul_prod[MUL_P_W-1:20];
        sin_diff = {s1_reg[CS_W-1], s1_reg} - {s0_reg[CS_W-1], s0_reg};
        cos_diff = {c0_reg[CS_W-1], c0_reg} - {c1_reg[CS_W-1], c1_reg};
        rad_mag  = (div_quo > R_LIM) ? R_LIM[POS_W-1:0] : div_quo[POS_W-1:0];
    end

    // shared unit operand selection
    always_comb
    begin
        mul_start = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        div_start = 1'b0;
        div_n     = '0;
        div_d     = '0;
        cor_start = 1'b0;
        cor_angle = yaw_reg;
        case (state_reg)
            S_ST_M1:
            begin
                mul_start = 1'b1;
                mul_a     = MUL_A_W'(r_reg);
                mul_b     = MUL_B_W'(dt_reg);
            end
            S_ST_C, S_TU_C0:
            begin
                cor_start = 1'b1;
            end
            S_ST_M2:
            begin
                mul_start = 1'b1;
                mul_a     = MUL_A_W'(dist_reg);
                mul_b     = MUL_B_W'(c0_reg);
            end
            S_ST_M3:
            begin
                mul_start = 1'b1;
                mul_a     = MUL_A_W'(dist_reg);
                mul_b     = MUL_B_W'(s0_reg);
            end
            S_TU_M1:
            begin
                mul_start = 1'b1;
                mul_a     = $signed(MUL_A_W'(w_eff));
                mul_b     = $signed(MUL_B_W'(mag_sum));
            end
            S_TU_D1:
            begin
                div_start = 1'b1;
                div_n     = p_reg;
                div_d     = DIV_D_W'({mag_diff, 1'b0});
            end
            S_TU_M2:
            begin
                mul_start = 1'b1;
                mul_a     = $signed(ANG_PER_RAD_Q8);
                mul_b     = $signed(MUL_B_W'(mag_diff));
            end
            S_TU_D2:
            begin
                div_start = 1'b1;
                div_n     = p_reg;
                div_d     = DIV_D_W'(w_eff);
            end
            S_TU_M3:
            begin
                mul_start = 1'b1;
                mul_a     = om_reg;
                mul_b     = MUL_B_W'(dt_reg);
            end
            S_TU_C1:
            begin
                cor_start = 1'b1;
                cor_angle = ny_reg;
            end
            S_TU_M4:
            begin
                mul_start = 1'b1;
                mul_a     = MUL_A_W'(rad_reg);
                mul_b     = MUL_B_W'(sin_diff);
            end
            S_TU_M5:
            begin
                mul_start = 1'b1;
                mul_a     = MUL_A_W'(rad_reg);
                mul_b     = MUL_B_W'(cos_diff);
            end
            default:
            begin
                mul_start = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    if (samples.opcode || !seen_first_reg)
                        state_next = S_FINISH;
                    else
                        state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                if (!moving)
                    state_next = S_FINISH;
                else if (straight)
                    state_next = S_ST_M1;
                else
                    state_next = S_TU_M1;
            end
            S_ST_M1:  state_next = S_ST_M1W;
            S_ST_M1W: if (mul_done) state_next = S_ST_C;
            S_ST_C:   state_next = S_ST_CW;
            S_ST_CW:  if (cor_done) state_next = S_ST_M2;
            S_ST_M2:  state_next = S_ST_M2W;
            S_ST_M2W: if (mul_done) state_next = S_ST_M3;
            S_ST_M3:  state_next = S_ST_M3W;
            S_ST_M3W: if (mul_done) state_next = S_FINISH;
            S_TU_M1:  state_next = S_TU_M1W;
            S_TU_M1W: if (mul_done) state_next = S_TU_D1;
            S_TU_D1:  state_next = S_TU_D1W;
            S_TU_D1W: if (div_done) state_next = S_TU_M2;
            S_TU_M2:  state_next = S_TU_M2W;
            S_TU_M2W: if (mul_done) state_next = S_TU_D2;
            S_TU_D2:  state_next = S_TU_D2W;
            S_TU_D2W: if (div_done) state_next = S_TU_M3;
            S_TU_M3:  state_next = S_TU_M3W;
            S_TU_M3W: if (mul_done) state_next = S_TU_C0;
            S_TU_C0:  state_next = S_TU_C0W;
            S_TU_C0W: if (cor_done) state_next = S_TU_C1;
            S_TU_C1:  state_next = S_TU_C1W;
            S_TU_C1W: if (cor_done) state_next = S_TU_M4;
            S_TU_M4:  state_next = S_TU_M4W;
            S_TU_M4W: if (mul_done) state_next = S_TU_M5;
            S_TU_M5:  state_next = S_TU_M5W;
            S_TU_M5W: if (mul_done) state_next = S_FINISH;
            S_FINISH: if (finish_go) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // control and pose state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            tw_reg         <= TW_RESET;
            thr_reg        <= THR_RESET;
            seen_first_reg <= 1'b0;
            last_time_reg  <= '0;
            pose_x_reg     <= '0;
            pose_y_reg     <= '0;
            yaw_reg        <= '0;
            mean_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg.valid)
            begin
                case (cfg.index)
                    REG_TRACK_WIDTH: tw_reg  <= cfg.data[TW_W-1:0];
                    REG_MOTION_THR:  thr_reg <= cfg.data[THR_W-1:0];
                    default:         tw_reg  <= tw_reg;
                endcase
            end

            if (in_xfer)
            begin
                if (samples.opcode)
                begin
                    pose_x_reg <= '0;
                    pose_y_reg <= '0;
                    yaw_reg    <= '0;
                end
                else
                begin
                    seen_first_reg <= 1'b1;
                    last_time_reg  <= samples.sample_time;
                end
            end

            if (state_reg == S_EVAL)
                mean_reg <= sum_w[SPD_W:1];

            if (mul_done)
            begin
                case (state_reg)
                    S_ST_M2W: pose_x_reg <= sat_add(pose_x_reg, mul_prod[MUL_P_W-1:30]);
                    S_ST_M3W: pose_y_reg <= sat_add(pose_y_reg, mul_prod[MUL_P_W-1:30]);
                    S_TU_M4W: pose_x_reg <= sat_add(pose_x_reg, mul_prod[MUL_P_W-1:30]);
                    S_TU_M5W:
                    begin
                        pose_y_reg <= sat_add(pose_y_reg, mul_prod[MUL_P_W-1:30]);
                        yaw_reg    <= ny_reg;
                    end
                    default: yaw_reg <= yaw_reg;
                endcase
            end

            if (finish_go)
                out_valid_reg <= 1'b1;
            else if (poses.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // working registers of one sample
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            r_reg       <= samples.right_speed;
            l_reg       <= samples.left_speed;
            dt_reg      <= samples.sample_time - last_time_reg;
            latched_reg <= !samples.opcode && !seen_first_reg;
        end

        case (state_reg)
            S_ST_M1W:
            begin
                if (d_full > DF_W'(D_LIM))
                    dist_reg <= D_LIM;
                else if (d_full < -DF_W'(D_LIM))
                    dist_reg <= -D_LIM;
                else
                    dist_reg <= d_full[CS_W-1:0];
            end
            S_ST_CW, S_TU_C0W:
            begin
                c0_reg <= cor_cos;
                s0_reg <= cor_sin;
            end
            S_TU_C1W:
            begin
                c1_reg <= cor_cos;
                s1_reg <= cor_sin;
            end
            S_TU_M1W, S_TU_M2W:
            begin
                p_reg <= mul_prod[DIV_N_W-1:0];
            end
            S_TU_D1W:
            begin
                // radius sign follows sum against difference
                if (sum_w[SPD_W] != diff_w[SPD_W])
                    rad_reg <= -$signed(rad_mag);
                else
                    rad_reg <= $signed(rad_mag);
            end
            S_TU_D2W:
            begin
                if (diff_w[SPD_W])
                    om_reg <= -$signed(div_quo);
                else
                    om_reg <= $signed(div_quo);
            end
            S_TU_M3W:
            begin
                ny_reg <= yaw_reg + mul_prod[DYAW_LSB+POS_W-1:DYAW_LSB];
            end
            default:
            begin
                ny_reg <= ny_reg;
            end
        endcase

        if (finish_go)
        begin
            out_x_reg       <= pose_x_reg;
            out_y_reg       <= pose_y_reg;
            out_yaw_reg     <= yaw_reg;
            out_mean_reg    <= mean_reg;
            out_latched_reg <= latched_reg;
        end
    end

    ddo_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    ddo_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_n),
        .divisor  (div_d),
        .done     (div_done),
        .quotient (div_quo)
    );

    ddo_cordic u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cor_start),
        .angle   (cor_angle),
        .done    (cor_done),
        .cos_val (cor_cos),
        .sin_val (cor_sin)
    );

    assign samples.ready = (state_reg == S_IDLE);
    assign cfg.ready     = 1'b1;

    assign poses.valid             = out_valid_reg;
    assign poses.pose_x            = out_x_reg;
    assign poses.pose_y            = out_y_reg;
    assign poses.pose_yaw          = out_yaw_reg;
    assign poses.mean_speed        = out_mean_reg;
    assign poses.time_latched_only = out_latched_reg;

    `DDO_ASSERT_NEXT(a_clear_zeroes_pose, in_xfer && samples.opcode,
        pose_x_reg == '0 && pose_y_reg == '0 && yaw_reg == '0)
    `DDO_ASSERT_SAME(a_no_unit_done_idle, state_reg == S_IDLE,
        !mul_done && !div_done && !cor_done)
    `DDO_ASSERT_NEXT(a_first_sample_latch, in_xfer && !samples.opcode && !seen_first_reg,
        seen_first_reg && last_time_reg == $past(samples.sample_time))

endmodule
